// File: hw/rtl/lce_pkg.sv
package lce_pkg;

   localparam int KEY_W  = 32;
   localparam int VAL_W  = 32;
   localparam int LIFE_W = 16;
   localparam int TIME_W = 32;
   localparam int EXP_W  = 33;
   localparam int CAP_W  = 5;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;
   localparam logic [LIFE_W-1:0] REFRESH_RESET  = 16'd60;

   // register select is the word address bit
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_REFRESH  = 1'b1;

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_PROMOTE,
      OP_REMOVE,
      OP_INSERT
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic                     kind;
      logic signed [KEY_W-1:0]  key;
      logic signed [VAL_W-1:0]  value;
      logic [LIFE_W-1:0]        lifetime;
      logic [TIME_W-1:0]        now;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [VAL_W-1:0]  read_value;
      logic                     expired;
      logic                     evicted;
      logic signed [KEY_W-1:0]  evicted_key;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      logic [EXP_W-1:0]  expiry;
   } entry_type;

   typedef struct packed {
      op_type op;
      logic   evict;
      logic   capture;
   } chain_ctrl_type;

   typedef struct packed {
      logic [CAP_W-1:0]  capacity;
      logic [LIFE_W-1:0] refresh_lifetime;
   } cfg_type;

endpackage

// File: hw/rtl/lce_cell.sv
module lce_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lce_pkg::chain_ctrl_type ctrl,
   input  logic [lce_pkg::KEY_W-1:0] req_key,
   input  lce_pkg::entry_type     left_entry,
   input  lce_pkg::entry_type     right_entry,
   input  logic                   seen_in,
   output logic                   seen_out,
   output logic                   match,
   output lce_pkg::entry_type     entry_q
);
   import lce_pkg::*;

   entry_type entry_ff, entry_in;
   logic      match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      if (ctrl.capture) begin
         match_in = entry_ff.valid && (entry_ff.key == req_key);
      end
      unique case (ctrl.op)
         OP_HOLD: begin
         end
         // cells up to the hit move one place back, the head takes the hit
         OP_PROMOTE: begin
            if (!seen_in) begin
               entry_in = left_entry;
            end
         end
         // cells from the removed one onwards close the gap
         OP_REMOVE: begin
            if (seen_in || match_ff) begin
               entry_in = right_entry;
            end
         end
         // everything moves back; the old least recent is dropped on eviction
         OP_INSERT: begin
            entry_in       = left_entry;
            entry_in.valid = left_entry.valid && !(ctrl.evict && !entry_ff.valid);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff.key    <= entry_in.key;
      entry_ff.value  <= entry_in.value;
      entry_ff.expiry <= entry_in.expiry;
      if (reset) begin
         entry_ff.valid <= 1'b0;
         match_ff       <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         match_ff       <= match_in;
      end
   end

   assign seen_out = seen_in | match_ff;
   assign match    = match_ff;
   assign entry_q  = entry_ff;

endmodule

// File: hw/rtl/lce_csr.sv
module lce_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [lce_pkg::CSR_AW-1:0] paddr,
   input  logic [lce_pkg::CSR_DW-1:0] pwdata,
   output logic [lce_pkg::CSR_DW-1:0] prdata,
   output logic                       pready,
   output lce_pkg::cfg_type           cfg
);
   import lce_pkg::*;

   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [LIFE_W-1:0] refresh_ff, refresh_in;
   logic              wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      refresh_in  = refresh_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_CAPACITY: capacity_in = pwdata[CAP_W-1:0];
            REG_REFRESH:  refresh_in  = pwdata[LIFE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_CAPACITY: prdata = CSR_DW'(capacity_ff);
         REG_REFRESH:  prdata = CSR_DW'(refresh_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         refresh_ff  <= REFRESH_RESET;
      end else begin
         capacity_ff <= capacity_in;
         refresh_ff  <= refresh_in;
      end
   end

   assign cfg.capacity         = capacity_ff;
   assign cfg.refresh_lifetime = refresh_ff;

endmodule

// File: hw/rtl/lru_cache_with_expiry_core.sv
// Fully associative key/value cache with least-recently-used replacement and
// per-entry expiry, held as a chain of cells ordered from most to least recent.
// Request channel: drive req_payload (get or put, key, value, lifetime, now)
// with start high; the request is taken at a clock edge where busy is low.
// Result channel: one result per request, shown on rsp_payload for exactly one
// cycle with rsp_strobe high. The receiver cannot stall the block.
// Sequence: key compare in every cell at the accepting edge, then an update
// state in which the chain shifts by one place; the result strobe is registered
// as the update state ends. busy is high for one cycle, so a new request is
// not taken until the block is through with the last one.
// Configuration: APB-style port, capacity at byte address 0, refresh_lifetime
// at address 4, pready always high; write only while the block is idle.
// Reset empties the cache and loads capacity 16 and refresh_lifetime 60.
module lru_cache_with_expiry_core #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lce_pkg::req_type           req_payload,
   output logic                       rsp_strobe,
   output lce_pkg::rsp_type           rsp_payload,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [lce_pkg::CSR_AW-1:0] paddr,
   input  logic [lce_pkg::CSR_DW-1:0] pwdata,
   output logic [lce_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import lce_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   cfg_type        cfg;
   state_type      state_ff, state_in;
   req_type        req_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   logic [CNT_W-1:0] count_ff, count_in;
   chain_ctrl_type ctrl;
   entry_type      head;
   entry_type      cell_q [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] match;
   logic [MAX_ENTRIES:0]   seen;
   logic [MAX_ENTRIES:0]   vld;
   logic           any_match;
   logic [VAL_W-1:0] sel_value;
   logic [EXP_W-1:0] sel_expiry;
   logic [KEY_W-1:0] lru_key;
   logic [CMP_W-1:0] cap_ext, cap_eff, count_ext, max_ext;
   logic             past_expiry, do_evict;

   lce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign seen[0]            = 1'b0;
   assign vld[MAX_ENTRIES]   = 1'b0;
   assign any_match          = seen[MAX_ENTRIES];

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type left_entry, right_entry;

      if (i == 0) begin : g_first
         assign left_entry = head;
      end else begin : g_mid_l
         assign left_entry = cell_q[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid_r
         assign right_entry = cell_q[i+1];
      end

      lce_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .req_key     (req_payload.key),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .seen_in     (seen[i]),
         .seen_out    (seen[i+1]),
         .match       (match[i]),
         .entry_q     (cell_q[i])
      );

      assign vld[i] = cell_q[i].valid;
   end

   // one-hot select of the hit entry and of the least recent valid entry
   always_comb begin
      sel_value  = '0;
      sel_expiry = '0;
      lru_key    = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         sel_value  = sel_value  | ({VAL_W{match[i]}} & cell_q[i].value);
         sel_expiry = sel_expiry | ({EXP_W{match[i]}} & cell_q[i].expiry);
         lru_key    = lru_key    | ({KEY_W{vld[i] & ~vld[i+1]}} & cell_q[i].key);
      end
   end

   always_comb begin
      cap_ext   = CMP_W'(cfg.capacity);
      max_ext   = CMP_W'(MAX_ENTRIES);
      count_ext = CMP_W'(count_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > max_ext) begin
         cap_eff = max_ext;
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign past_expiry = {1'b0, req_ff.now} > sel_expiry;
   assign do_evict    = (count_ext >= cap_eff) && (count_ff != '0);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ctrl.op       = OP_HOLD;
      ctrl.evict    = 1'b0;
      ctrl.capture  = 1'b0;
      head.valid    = 1'b1;
      head.key      = req_ff.key;
      head.value    = req_ff.value;
      head.expiry   = {1'b0, req_ff.now} + EXP_W'(cfg.refresh_lifetime);
      rsp_in        = '0;
      rsp_strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.capture = 1'b1;
               state_in     = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            if (req_ff.kind == KIND_GET) begin
               if (any_match && past_expiry) begin
                  ctrl.op        = OP_REMOVE;
                  count_in       = count_ff - CNT_W'(1);
                  rsp_in.expired = 1'b1;
               end else if (any_match) begin
                  ctrl.op           = OP_PROMOTE;
                  head.value        = sel_value;
                  rsp_in.hit        = 1'b1;
                  rsp_in.read_value = sel_value;
               end
            end else if (any_match) begin
               ctrl.op    = OP_PROMOTE;
               rsp_in.hit = 1'b1;
            end else begin
               ctrl.op     = OP_INSERT;
               ctrl.evict  = do_evict;
               head.expiry = {1'b0, req_ff.now} + EXP_W'(req_ff.lifetime);
               if (do_evict) begin
                  rsp_in.evicted     = 1'b1;
                  rsp_in.evicted_key = lru_key;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_payload;
      end
      if (rsp_strobe_in) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy        = (state_ff == ST_UPDATE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
